### rtl/assert_macros.svh
// Assertion macros shared by the branch target fixup RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define SBTF_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication checked at every clock edge out of reset.
`define SBTF_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

### rtl/sbtf_pkg.sv
// Types and constants shared by the branch target fixup modules.
`default_nettype none

package sbtf_pkg;

  localparam int unsigned STACK_DEPTH_DEF = 32;
  localparam int unsigned MAX_MIDS_DEF    = 16;
  localparam int unsigned QUEUE_DEPTH     = 2;
  localparam int unsigned ID_W            = 16;
  localparam int unsigned ADDR_W          = 17;
  localparam int unsigned STEP_PLAIN      = 2;
  localparam int unsigned STEP_EXT        = 4;

  // Incoming command codes
  typedef enum logic [1:0] {
    CMD_PUSH = 2'd0,
    CMD_POP  = 2'd1,
    CMD_MID  = 2'd2
  } cmd_e;

  // Completion status of a command
  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_MISMATCH = 3'd2,
    ST_NOLOOP   = 3'd3,
    ST_OVERFLOW = 3'd4
  } status_e;

  // Work handed from the front to the back
  typedef enum logic [1:0] {
    OP_PLAIN    = 2'd0,
    OP_MID      = 2'd1,
    OP_IF_POP   = 2'd2,
    OP_LOOP_POP = 2'd3
  } op_e;

  // Back end sequencer states
  typedef enum logic [1:0] {
    BK_IDLE       = 2'd0,
    BK_IF_READ    = 2'd1,
    BK_LOOP_START = 2'd2,
    BK_LOOP_MIDS  = 2'd3
  } bk_state_e;

  typedef struct packed {
    op_e               op;
    status_e           status;
    logic              patch;
    logic [ID_W-1:0]   id;
    logic [ID_W-1:0]   start;
    logic              ext;
  } desc_t;

endpackage

`default_nettype wire

### rtl/sbtf_ram.sv
// Generic single write port RAM with registered read.
`default_nettype none

module sbtf_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 512,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

### rtl/sbtf_queue.sv
// Small FIFO decoupling the front end from the back end.
`default_nettype none
`include "assert_macros.svh"

module sbtf_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2,
  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned NW = $clog2(DEPTH + 1)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic                  valid_o,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [NW-1:0]    count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == NW'(DEPTH));
  assign valid_o = (count_q != '0);
  assign rdata_o = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Pointer and fill level update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + NW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - NW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage slots
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= wdata_i;
    end
  end

  `SBTF_ASSERT(a_queue_level, count_q <= NW'(DEPTH), "queue fill level beyond depth")

endmodule

`default_nettype wire

### rtl/sbtf_front.sv
// Front end: accepts commands, keeps the frame and loop stacks, classifies work.
`default_nettype none
`include "assert_macros.svh"

module sbtf_front #(
  parameter int unsigned STACK_DEPTH = sbtf_pkg::STACK_DEPTH_DEF,
  parameter int unsigned MAX_MIDS    = sbtf_pkg::MAX_MIDS_DEF,
  localparam int unsigned FW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1,
  localparam int unsigned TW = $clog2(STACK_DEPTH + 1),
  localparam int unsigned CW = $clog2(MAX_MIDS + 1),
  localparam int unsigned MD = STACK_DEPTH * MAX_MIDS,
  localparam int unsigned AW = (MD > 1) ? $clog2(MD) : 1
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_stall_o,
  input  wire logic [1:0]                command_i,
  input  wire logic                      jump_kind_i,
  input  wire logic [sbtf_pkg::ID_W-1:0] cf_id_i,
  input  wire logic                      extended_alu_i,
  output logic                           q_push_o,
  output sbtf_pkg::desc_t                q_desc_o,
  output logic [AW-1:0]                  q_addr_o,
  output logic [CW-1:0]                  q_n_o,
  input  wire logic                      q_full_i
);

  // Frame stack entries; only entries below the tops are read
  logic                      kind_q  [STACK_DEPTH];
  logic [sbtf_pkg::ID_W-1:0] start_q [STACK_DEPTH];
  logic [CW-1:0]             cnt_q   [STACK_DEPTH];
  logic [FW-1:0]             lidx_q  [STACK_DEPTH];

  logic [TW-1:0] top_q, top_d;
  logic [TW-1:0] ltop_q, ltop_d;
  logic [TW-1:0] top_m1, ltop_m1;
  logic [FW-1:0] top_idx, push_idx, loop_f, mid_f, cnt_idx;
  logic [CW-1:0] mid_n, pop_n, cnt_wdata;
  logic          accept;
  logic          wr_frame, wr_loop, wr_cnt;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign q_push_o   = accept;

  assign top_m1   = top_q - TW'(1);
  assign ltop_m1  = ltop_q - TW'(1);
  assign top_idx  = top_m1[FW-1:0];
  assign push_idx = top_q[FW-1:0];
  assign loop_f   = lidx_q[ltop_m1[FW-1:0]];
  assign mid_f    = jump_kind_i ? loop_f : top_idx;
  assign mid_n    = cnt_q[mid_f];
  assign pop_n    = (cnt_q[top_idx] >= CW'(MAX_MIDS)) ? CW'(MAX_MIDS) : cnt_q[top_idx];

  // Command classification and stack bookkeeping
  always_comb begin
    q_desc_o        = '0;
    q_desc_o.op     = sbtf_pkg::OP_PLAIN;
    q_desc_o.status = sbtf_pkg::ST_OK;
    q_desc_o.id     = cf_id_i;
    q_desc_o.ext    = extended_alu_i;
    q_addr_o        = '0;
    q_n_o           = '0;
    top_d           = top_q;
    ltop_d          = ltop_q;
    wr_frame        = 1'b0;
    wr_loop         = 1'b0;
    wr_cnt          = 1'b0;
    cnt_idx         = push_idx;
    cnt_wdata       = '0;
    case (sbtf_pkg::cmd_e'(command_i))
      sbtf_pkg::CMD_PUSH: begin
        if (top_q == TW'(STACK_DEPTH) || (jump_kind_i && ltop_q == TW'(STACK_DEPTH))) begin
          q_desc_o.status = sbtf_pkg::ST_OVERFLOW;
        end else begin
          wr_frame = 1'b1;
          wr_cnt   = 1'b1;
          top_d    = top_q + TW'(1);
          if (jump_kind_i) begin
            wr_loop = 1'b1;
            ltop_d  = ltop_q + TW'(1);
          end
        end
      end
      sbtf_pkg::CMD_MID: begin
        if (top_q == '0) begin
          q_desc_o.status = sbtf_pkg::ST_EMPTY;
        end else if (jump_kind_i && (ltop_q == '0 || TW'(loop_f) >= top_q)) begin
          q_desc_o.status = sbtf_pkg::ST_NOLOOP;
        end else if (mid_n >= CW'(MAX_MIDS)) begin
          q_desc_o.status = sbtf_pkg::ST_OVERFLOW;
        end else begin
          q_desc_o.op    = sbtf_pkg::OP_MID;
          q_desc_o.patch = !kind_q[mid_f];
          q_desc_o.start = start_q[mid_f];
          q_addr_o       = AW'(AW'(mid_f) * AW'(MAX_MIDS)) + AW'(mid_n);
          wr_cnt         = 1'b1;
          cnt_idx        = mid_f;
          cnt_wdata      = mid_n + CW'(1);
        end
      end
      sbtf_pkg::CMD_POP: begin
        if (top_q == '0) begin
          q_desc_o.status = sbtf_pkg::ST_EMPTY;
        end else if (kind_q[top_idx] != jump_kind_i) begin
          q_desc_o.status = sbtf_pkg::ST_MISMATCH;
        end else begin
          q_desc_o.op    = jump_kind_i ? sbtf_pkg::OP_LOOP_POP : sbtf_pkg::OP_IF_POP;
          q_desc_o.start = start_q[top_idx];
          q_addr_o       = AW'(AW'(top_idx) * AW'(MAX_MIDS));
          q_n_o          = pop_n;
          top_d          = top_m1;
          if (jump_kind_i && ltop_q != '0) begin
            ltop_d = ltop_m1;
          end
        end
      end
      default: begin
        q_desc_o.status = sbtf_pkg::ST_OK;
      end
    endcase
  end

  // Stack pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q  <= '0;
      ltop_q <= '0;
    end else if (accept) begin
      top_q  <= top_d;
      ltop_q <= ltop_d;
    end
  end

  // Stack entries
  always_ff @(posedge clk_i) begin
    if (accept) begin
      if (wr_frame) begin
        kind_q[push_idx]  <= jump_kind_i;
        start_q[push_idx] <= cf_id_i;
      end
      if (wr_loop) begin
        lidx_q[ltop_q[FW-1:0]] <= push_idx;
      end
      if (wr_cnt) begin
        cnt_q[cnt_idx] <= cnt_wdata;
      end
    end
  end

  `SBTF_ASSERT(a_loop_within_frames, ltop_q <= top_q, "more loops open than frames")
  `SBTF_ASSERT(a_top_bounded, top_q <= TW'(STACK_DEPTH), "frame stack pointer out of range")

endmodule

`default_nettype wire

### rtl/sbtf_back.sv
// Back end: records mid jumps and streams the address patches out.
`default_nettype none
`include "assert_macros.svh"

module sbtf_back #(
  parameter int unsigned STACK_DEPTH = sbtf_pkg::STACK_DEPTH_DEF,
  parameter int unsigned MAX_MIDS    = sbtf_pkg::MAX_MIDS_DEF,
  localparam int unsigned CW = $clog2(MAX_MIDS + 1),
  localparam int unsigned MD = STACK_DEPTH * MAX_MIDS,
  localparam int unsigned AW = (MD > 1) ? $clog2(MD) : 1
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        q_valid_i,
  input  wire sbtf_pkg::desc_t             q_desc_i,
  input  wire logic [AW-1:0]               q_addr_i,
  input  wire logic [CW-1:0]               q_n_i,
  output logic                             q_pop_o,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic                             patch_valid_o,
  output logic [sbtf_pkg::ID_W-1:0]        patch_target_o,
  output logic [sbtf_pkg::ADDR_W-1:0]      patch_addr_o,
  output logic                             patch_sets_pop_o,
  output logic [2:0]                       status_o,
  output logic                             last_o
);

  localparam int unsigned AdW = sbtf_pkg::ADDR_W;

  sbtf_pkg::bk_state_e state_q, state_d;
  sbtf_pkg::desc_t     desc_q, desc_d;
  logic [AW-1:0]       base_q, base_d;
  logic [CW-1:0]       n_q, n_d;
  logic [CW-1:0]       k_q, k_d;

  logic                      load;
  logic                      ram_we;
  logic [AW-1:0]             ram_raddr;
  logic [sbtf_pkg::ID_W-1:0] ram_rdata;

  logic                      em_valid, em_patch, em_pop, em_last;
  logic [sbtf_pkg::ID_W-1:0] em_target;
  logic [AdW-1:0]            em_addr;
  sbtf_pkg::status_e         em_status;

  logic                      out_valid_q;
  logic                      out_patch_q, out_pop_q, out_last_q;
  logic [sbtf_pkg::ID_W-1:0] out_target_q;
  logic [AdW-1:0]            out_addr_q;
  sbtf_pkg::status_e         out_status_q;

  logic [AdW-1:0] head_pop_addr, cur_pop_addr, cur_id_p2;

  // Output register takes a new transaction when empty or being drained
  assign load = !out_valid_q || !out_stall_i;

  assign head_pop_addr = AdW'(q_desc_i.id) +
                         (q_desc_i.ext ? AdW'(sbtf_pkg::STEP_EXT) : AdW'(sbtf_pkg::STEP_PLAIN));
  assign cur_pop_addr  = AdW'(desc_q.id) +
                         (desc_q.ext ? AdW'(sbtf_pkg::STEP_EXT) : AdW'(sbtf_pkg::STEP_PLAIN));
  assign cur_id_p2     = AdW'(desc_q.id) + AdW'(sbtf_pkg::STEP_PLAIN);

  // Mid jump store
  sbtf_ram #(
    .WIDTH (sbtf_pkg::ID_W),
    .DEPTH (MD)
  ) u_mid_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (q_addr_i),
    .wdata_i (q_desc_i.id),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Sequencer: next state, RAM read address and the result to emit
  always_comb begin
    state_d   = state_q;
    desc_d    = desc_q;
    base_d    = base_q;
    n_d       = n_q;
    k_d       = k_q;
    q_pop_o   = 1'b0;
    ram_we    = 1'b0;
    ram_raddr = base_q;
    em_valid  = 1'b0;
    em_patch  = 1'b0;
    em_target = '0;
    em_addr   = '0;
    em_pop    = 1'b0;
    em_status = sbtf_pkg::ST_OK;
    em_last   = 1'b1;
    case (state_q)
      sbtf_pkg::BK_IDLE: begin
        ram_raddr = q_addr_i;
        if (q_valid_i && load) begin
          q_pop_o = 1'b1;
          desc_d  = q_desc_i;
          base_d  = q_addr_i;
          n_d     = q_n_i;
          case (q_desc_i.op)
            sbtf_pkg::OP_PLAIN: begin
              em_valid  = 1'b1;
              em_status = q_desc_i.status;
            end
            sbtf_pkg::OP_MID: begin
              ram_we   = 1'b1;
              em_valid = 1'b1;
              if (q_desc_i.patch) begin
                em_patch  = 1'b1;
                em_target = q_desc_i.start;
                em_addr   = AdW'(q_desc_i.id);
              end
            end
            sbtf_pkg::OP_IF_POP: begin
              if (q_n_i == '0) begin
                em_valid  = 1'b1;
                em_patch  = 1'b1;
                em_target = q_desc_i.start;
                em_addr   = head_pop_addr;
                em_pop    = 1'b1;
              end else begin
                state_d = sbtf_pkg::BK_IF_READ;
              end
            end
            sbtf_pkg::OP_LOOP_POP: begin
              em_valid  = 1'b1;
              em_patch  = 1'b1;
              em_target = q_desc_i.id;
              em_addr   = AdW'(q_desc_i.start) + AdW'(sbtf_pkg::STEP_PLAIN);
              em_last   = 1'b0;
              state_d   = sbtf_pkg::BK_LOOP_START;
            end
            default: begin
              em_valid = 1'b1;
            end
          endcase
        end
      end
      sbtf_pkg::BK_IF_READ: begin
        // first mid of the frame takes the jump past the end
        if (load) begin
          em_valid  = 1'b1;
          em_patch  = 1'b1;
          em_target = ram_rdata;
          em_addr   = cur_pop_addr;
          em_pop    = 1'b1;
          state_d   = sbtf_pkg::BK_IDLE;
        end
      end
      sbtf_pkg::BK_LOOP_START: begin
        // prefetch the first mid while the start patch goes out
        if (load) begin
          em_valid  = 1'b1;
          em_patch  = 1'b1;
          em_target = desc_q.start;
          em_addr   = cur_id_p2;
          em_last   = (n_q == '0);
          k_d       = '0;
          state_d   = (n_q == '0) ? sbtf_pkg::BK_IDLE : sbtf_pkg::BK_LOOP_MIDS;
        end
      end
      sbtf_pkg::BK_LOOP_MIDS: begin
        ram_raddr = base_q + AW'(k_q);
        if (load) begin
          em_valid  = 1'b1;
          em_patch  = 1'b1;
          em_target = ram_rdata;
          em_addr   = AdW'(desc_q.id);
          k_d       = k_q + CW'(1);
          em_last   = (k_d == n_q);
          ram_raddr = base_q + AW'(k_d);
          if (em_last) begin
            state_d = sbtf_pkg::BK_IDLE;
          end
        end
      end
      default: begin
        state_d = sbtf_pkg::BK_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sbtf_pkg::BK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load) begin
        out_valid_q <= em_valid;
      end
    end
  end

  // Working registers and output payload
  always_ff @(posedge clk_i) begin
    desc_q <= desc_d;
    base_q <= base_d;
    n_q    <= n_d;
    k_q    <= k_d;
    if (load) begin
      out_patch_q  <= em_patch;
      out_target_q <= em_target;
      out_addr_q   <= em_addr;
      out_pop_q    <= em_pop;
      out_status_q <= em_status;
      out_last_q   <= em_last;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign patch_valid_o    = out_patch_q;
  assign patch_target_o   = out_target_q;
  assign patch_addr_o     = out_addr_q;
  assign patch_sets_pop_o = out_pop_q;
  assign status_o         = out_status_q;
  assign last_o           = out_last_q;

  `SBTF_ASSERT_IMP(a_mid_index, state_q == sbtf_pkg::BK_LOOP_MIDS, k_q < n_q,
                   "mid stream index past recorded count")
  `SBTF_ASSERT_IMP(a_pop_only_idle, state_q != sbtf_pkg::BK_IDLE, !q_pop_o,
                   "queue popped while a pop is still streaming")

endmodule

`default_nettype wire

### rtl/structured_branch_target_fixup.sv
// Top level of the structured branch target fixup block.
// A command's first result passes through the work queue and the output register; an if
// pop with mids also waits for its mid jump RAM read. The front end takes one command per
// cycle while the queue has room. The back end pops no queue entry while a pop streams;
// mid patches come one per cycle out of the mid jump RAM port unless the output stalls.
// Reset: asynchronous active low; clears stack pointers, queue and output valid.
`default_nettype none

module structured_branch_target_fixup #(
  parameter int unsigned STACK_DEPTH = sbtf_pkg::STACK_DEPTH_DEF,
  parameter int unsigned MAX_MIDS    = sbtf_pkg::MAX_MIDS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [1:0]                    command_i,
  input  wire logic                          jump_kind_i,
  input  wire logic [sbtf_pkg::ID_W-1:0]     cf_id_i,
  input  wire logic                          extended_alu_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic                               patch_valid_o,
  output logic [sbtf_pkg::ID_W-1:0]          patch_target_o,
  output logic [sbtf_pkg::ADDR_W-1:0]        patch_addr_o,
  output logic                               patch_sets_pop_o,
  output logic [2:0]                         status_o,
  output logic                               last_o
);

  localparam int unsigned CW = $clog2(MAX_MIDS + 1);
  localparam int unsigned MD = STACK_DEPTH * MAX_MIDS;
  localparam int unsigned AW = (MD > 1) ? $clog2(MD) : 1;
  localparam int unsigned QW = $bits(sbtf_pkg::desc_t) + AW + CW;

  logic            q_push, q_full, q_pop, q_valid;
  sbtf_pkg::desc_t push_desc, head_desc;
  logic [AW-1:0]   push_addr, head_addr;
  logic [CW-1:0]   push_n, head_n;
  logic [QW-1:0]   q_wdata, q_rdata;

  assign q_wdata = {push_desc, push_addr, push_n};
  assign {head_desc, head_addr, head_n} = q_rdata;

  // Command intake and stack bookkeeping
  sbtf_front #(
    .STACK_DEPTH (STACK_DEPTH),
    .MAX_MIDS    (MAX_MIDS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .command_i      (command_i),
    .jump_kind_i    (jump_kind_i),
    .cf_id_i        (cf_id_i),
    .extended_alu_i (extended_alu_i),
    .q_push_o       (q_push),
    .q_desc_o       (push_desc),
    .q_addr_o       (push_addr),
    .q_n_o          (push_n),
    .q_full_i       (q_full)
  );

  // Work queue between the two halves
  sbtf_queue #(
    .WIDTH (QW),
    .DEPTH (sbtf_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .rdata_o (q_rdata)
  );

  // Mid recording and patch streaming
  sbtf_back #(
    .STACK_DEPTH (STACK_DEPTH),
    .MAX_MIDS    (MAX_MIDS)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_valid_i        (q_valid),
    .q_desc_i         (head_desc),
    .q_addr_i         (head_addr),
    .q_n_i            (head_n),
    .q_pop_o          (q_pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .patch_valid_o    (patch_valid_o),
    .patch_target_o   (patch_target_o),
    .patch_addr_o     (patch_addr_o),
    .patch_sets_pop_o (patch_sets_pop_o),
    .status_o         (status_o),
    .last_o           (last_o)
  );

endmodule

`default_nettype wire
